[hdl/hte_pkg.sv]
// Package for the homogeneous transform engine: command codes, widths,
// controller state type, channel payloads and the command/status structs. No dependencies.
package hte_pkg;

	localparam int FracBitsDef = 16;
	localparam int DataW = 32;
	localparam int AccW = 68;

	typedef enum logic [2:0] {
		CMD_IDENT = 3'd0,
		CMD_TRANS = 3'd1,
		CMD_SCALE = 3'd2,
		CMD_ROT   = 3'd3,
		CMD_PROJ  = 3'd4,
		CMD_POINT = 3'd5,
		CMD_RSV6  = 3'd6,
		CMD_RSV7  = 3'd7
	} cmd_t;

	localparam logic [1:0] AXIS_X = 2'd1;
	localparam logic [1:0] AXIS_Y = 2'd2;
	localparam logic [1:0] AXIS_Z = 2'd3;

	// input transaction
	typedef struct packed {
		cmd_t                     cmd;
		logic [1:0]               axis;
		logic signed [DataW-1:0]  op_a;
		logic signed [DataW-1:0]  op_b;
		logic signed [DataW-1:0]  op_c;
		logic signed [DataW-1:0]  op_d;
		logic signed [DataW-1:0]  op_e;
		logic signed [DataW-1:0]  op_f;
		logic signed [DataW-1:0]  op_g;
		logic signed [DataW-1:0]  op_h;
		logic signed [DataW-1:0]  op_i;
	} hte_in_t;

	// result transaction
	typedef struct packed {
		logic                     status;
		logic signed [DataW-1:0]  out_x;
		logic signed [DataW-1:0]  out_y;
		logic signed [DataW-1:0]  out_z;
		logic signed [DataW-1:0]  out_w;
	} hte_out_t;

	// Datapath operation codes issued by the controller.
	typedef enum logic [3:0] {
		OP_NONE,      // hold
		OP_IDENT,     // load identity into matrix
		OP_ELEM,      // build elementary matrix (non-projection)
		OP_PDOT,      // one term of div/num dot products (index = k)
		OP_PSAT,      // saturate div/num
		OP_DIVSTART,  // start a division (index selects operands)
		OP_DIVWAIT,   // wait for divider
		OP_PFILL,     // write a projection element from the quotient
		OP_MAC,       // one MAC term of E*M or M*p (index r,c,k)
		OP_MSTORE,    // store saturated accumulator in scratch, or E[i][3] when idx[4]
		OP_COMMIT,    // copy scratch to matrix
		OP_PSTORE,    // store point component
		OP_OUT        // load the result register
	} dop_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ELEM,
		ST_PDOT,
		ST_PSAT,
		ST_DSTART,
		ST_DWAIT,
		ST_PFILL,
		ST_MAC,
		ST_MSTORE,
		ST_COMMIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		dop_t       op;
		logic [4:0] idx;   // element or division index
		logic [1:0] k;     // MAC term
		logic       pt;    // MAC for point
		logic       clr;   // clear accumulator
	} hte_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic div_zero;
	} hte_stat_t;

	function automatic logic signed [DataW-1:0] sat32(input logic signed [AccW-1:0] v);
		logic signed [AccW-1:0] mx;
		logic signed [AccW-1:0] mn;
		mx = AccW'(signed'({1'b0, {(DataW-1){1'b1}}}));
		mn = -mx - AccW'(1);
		if (v > mx) return mx[DataW-1:0];
		if (v < mn) return mn[DataW-1:0];
		return v[DataW-1:0];
	endfunction

endpackage

[hdl/hte_if.sv]
// Valid/ready channel interface carrying one payload of type PT_T.
// Depends on nothing.
interface hte_if #(parameter type PT_T = logic) ();
	logic valid;
	logic ready;
	PT_T  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/hte_div.sv]
// Restoring divider: (a << FRAC_BITS) / b truncated toward zero, saturated.
// Uses hte_pkg for widths; one quotient bit per cycle.
module hte_div #(
	parameter int FRAC_BITS = hte_pkg::FracBitsDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [hte_pkg::DataW-1:0] a,
	input  logic signed [hte_pkg::DataW-1:0] b,
	output logic busy,
	output logic signed [hte_pkg::DataW-1:0] q
);
	localparam int NW = hte_pkg::DataW + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [NW:0] rem_q;
	logic [hte_pkg::DataW-1:0] den_q;
	logic neg_q;
	logic [CW-1:0] cnt_q;
	logic [NW:0] trial;
	logic [NW:0] shifted;
	logic signed [hte_pkg::AccW-1:0] sq;

	assign shifted = {rem_q[NW-1:0], num_q[NW-1]};
	assign trial = shifted - (NW+1)'(den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {(a[hte_pkg::DataW-1] ? -a : a), {FRAC_BITS{1'b0}}};
			den_q <= b[hte_pkg::DataW-1] ? -b : b;
			neg_q <= a[hte_pkg::DataW-1] ^ b[hte_pkg::DataW-1];
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[NW-2:0], ~trial[NW]};
			rem_q <= trial[NW] ? shifted : trial;
		end
	end

	// quotient magnitude sits in num_q; unsigned den for -2^31 works via wrap
	always_comb begin
		sq = neg_q ? -hte_pkg::AccW'(num_q) : hte_pkg::AccW'(num_q);
		q = hte_pkg::sat32(sq);
	end

	assign busy = (cnt_q != '0);
endmodule

[hdl/hte_datapath.sv]
// Datapath: matrix, elementary and scratch register files, one shared
// MAC unit and the divider. Depends on hte_pkg and hte_div.
module hte_datapath #(
	parameter int FRAC_BITS = hte_pkg::FracBitsDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  logic [2:0] cmd,
	input  logic [1:0] axis,
	input  logic signed [hte_pkg::DataW-1:0] ops [9],
	input  hte_pkg::hte_cmd_t dc,
	output hte_pkg::hte_stat_t ds,
	output logic signed [hte_pkg::DataW-1:0] pout [4]
);
	localparam int W = hte_pkg::DataW;
	localparam int A = hte_pkg::AccW;
	localparam logic signed [W-1:0] ONE = W'(1) <<< FRAC_BITS;

	logic signed [W-1:0] m_q [16];
	logic signed [W-1:0] e_q [16];
	logic signed [W-1:0] s_q [16];
	logic signed [W-1:0] elem_d [16];
	logic signed [W-1:0] op_q [9];
	logic signed [W-1:0] pacc_q [4];
	logic [1:0] axis_q;
	logic [2:0] cmd_q;
	logic signed [A-1:0] acc_q;
	logic signed [W-1:0] div_q, num_q, q_q;
	logic signed [A-1:0] dot_acc_q, num_acc_q;

	logic signed [W-1:0] ma, mb;
	logic signed [2*W-1:0] prod_s1;
	logic mac_v_s1, clr_s1;
	logic [1:0] r, c, k;
	logic [3:0] k4, ci4;
	logic signed [W-1:0] da, db, dq;
	logic dstart, dbusy;
	logic signed [W-1:0] rc, nk, ck;
	logic signed [W-1:0] ns;

	assign r = dc.idx[3:2];
	assign c = dc.idx[1:0];
	assign k = dc.k;
	assign k4 = {2'b00, k};
	assign ci4 = {2'b00, dc.idx[1:0]};

	always_comb begin
		rc = hte_pkg::sat32(A'(op_q[4'd3 + k4]) - A'(op_q[4'd6 + k4]));
		nk = op_q[k4];
		ck = op_q[4'd6 + k4];
		ns = hte_pkg::sat32(-A'(op_q[1]));
		ma = '0;
		mb = '0;
		if (dc.op == hte_pkg::OP_PDOT) begin
			ma = dc.idx[0] ? ck : rc;
			mb = nk;
		end else if (dc.op == hte_pkg::OP_MAC) begin
			if (dc.pt) begin
				ma = m_q[{c, k}];
				mb = (k == 2'd3) ? ONE : op_q[k4];
			end else begin
				ma = e_q[{r, k}];
				mb = m_q[{k, c}];
			end
		end
	end

	// elementary matrix for translate, scale and rotate
	always_comb begin
		for (int i = 0; i < 16; i++) elem_d[i] = (i % 5 == 0) ? ONE : '0;
		if (cmd_q == hte_pkg::CMD_TRANS) begin
			elem_d[3] = op_q[0]; elem_d[7] = op_q[1]; elem_d[11] = op_q[2];
		end else if (cmd_q == hte_pkg::CMD_SCALE) begin
			elem_d[0] = op_q[0]; elem_d[5] = op_q[1]; elem_d[10] = op_q[2];
		end else if (axis_q == hte_pkg::AXIS_X) begin
			elem_d[5] = op_q[0]; elem_d[6] = ns; elem_d[9] = op_q[1]; elem_d[10] = op_q[0];
		end else if (axis_q == hte_pkg::AXIS_Y) begin
			elem_d[0] = op_q[0]; elem_d[2] = op_q[1]; elem_d[8] = ns; elem_d[10] = op_q[0];
		end else begin
			elem_d[0] = op_q[0]; elem_d[1] = ns; elem_d[4] = op_q[1]; elem_d[5] = op_q[0];
		end
	end

	// one multiplier, registered, then floor shift and accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_v_s1 <= 1'b0;
			clr_s1 <= 1'b0;
		end else begin
			mac_v_s1 <= (dc.op == hte_pkg::OP_MAC) || (dc.op == hte_pkg::OP_PDOT);
			clr_s1 <= dc.clr;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= ma * mb;
		if (mac_v_s1) begin
			acc_q <= (clr_s1 ? '0 : acc_q) + A'(prod_s1 >>> FRAC_BITS);
		end
	end

	// projection division operands by index: 0 q, 1..9 C_i*N_j, 10..12 N_i
	logic [3:0] di;
	logic [1:0] pi, pj;
	logic signed [2*W-1:0] cn;
	assign di = dc.idx[3:0];
	always_comb begin
		pi = 2'd0;
		pj = 2'd0;
		case (di)
			4'd1: begin pi = 2'd0; pj = 2'd0; end
			4'd2: begin pi = 2'd0; pj = 2'd1; end
			4'd3: begin pi = 2'd0; pj = 2'd2; end
			4'd4: begin pi = 2'd1; pj = 2'd0; end
			4'd5: begin pi = 2'd1; pj = 2'd1; end
			4'd6: begin pi = 2'd1; pj = 2'd2; end
			4'd7: begin pi = 2'd2; pj = 2'd0; end
			4'd8: begin pi = 2'd2; pj = 2'd1; end
			4'd9: begin pi = 2'd2; pj = 2'd2; end
			default: ;
		endcase
		cn = op_q[4'd6 + {2'b00, pi}] * op_q[{2'b00, pj}];
		da = num_q;
		db = div_q;
		if (di >= 4'd1 && di <= 4'd9) begin
			da = hte_pkg::sat32(A'(cn >>> FRAC_BITS));
		end else if (di >= 4'd10) begin
			da = op_q[di - 4'd10];
		end
	end
	assign dstart = (dc.op == hte_pkg::OP_DIVSTART);

	hte_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .a(da), .b(db),
		.busy(dbusy), .q(dq)
	);

	logic signed [2*W-1:0] qc;
	assign qc = q_q * op_q[4'd6 + ci4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) m_q[i] <= (i % 5 == 0) ? ONE : '0;
		end else if (dc.op == hte_pkg::OP_IDENT) begin
			for (int i = 0; i < 16; i++) m_q[i] <= (i % 5 == 0) ? ONE : '0;
		end else if (dc.op == hte_pkg::OP_COMMIT) begin
			m_q <= s_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			op_q <= ops;
			axis_q <= axis;
			cmd_q <= cmd;
		end
		case (dc.op)
			hte_pkg::OP_ELEM: e_q <= elem_d;
			hte_pkg::OP_PSAT: begin
				div_q <= hte_pkg::sat32(dot_acc_q);
				num_q <= hte_pkg::sat32(num_acc_q);
			end
			hte_pkg::OP_PFILL: begin
				if (di == 4'd0) begin
					q_q <= dq;
					e_q[15] <= hte_pkg::sat32(-A'(dq));
				end else if (di <= 4'd9) begin
					e_q[{pi, pj}] <= hte_pkg::sat32(A'(dq) + ((pi == pj) ? A'(ONE) : '0));
				end else begin
					e_q[{2'd3, 2'(di - 4'd10)}] <= dq;
				end
			end
			hte_pkg::OP_MSTORE: begin
				if (dc.idx[4]) begin
					// E[i][3] = -C_i - q*C_i, i in idx[1:0]
					e_q[{dc.idx[1:0], 2'd3}] <= hte_pkg::sat32(
						-A'(op_q[4'd6 + ci4])
						- A'(hte_pkg::sat32(A'(qc >>> FRAC_BITS))));
				end else begin
					s_q[dc.idx[3:0]] <= hte_pkg::sat32(acc_q);
				end
			end
			hte_pkg::OP_PSTORE: pacc_q[dc.idx[1:0]] <= hte_pkg::sat32(acc_q);
			hte_pkg::OP_OUT: pout <= pacc_q;
			default: ;
		endcase
	end

	// dot products: idx[0]=0 accumulates (R-C).N, idx[0]=1 C.N, in acc_q order
	logic pdot_s1, pdot_sel_s1, pdot_clr_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pdot_s1 <= 1'b0;
		end else begin
			pdot_s1 <= (dc.op == hte_pkg::OP_PDOT);
		end
	end
	always_ff @(posedge clk) begin
		pdot_sel_s1 <= dc.idx[0];
		pdot_clr_s1 <= dc.clr;
		if (pdot_s1) begin
			if (pdot_sel_s1)
				num_acc_q <= (pdot_clr_s1 ? '0 : num_acc_q) + A'(prod_s1 >>> FRAC_BITS);
			else
				dot_acc_q <= (pdot_clr_s1 ? '0 : dot_acc_q) + A'(prod_s1 >>> FRAC_BITS);
		end
	end

	assign ds.div_busy = dbusy;
	assign ds.div_zero = (div_q == '0);
endmodule

[hdl/hte_ctrl.sv]
// Controller state machine sequencing the datapath for each command.
// Depends on hte_pkg only.
module hte_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [2:0] cmd,
	input  logic [1:0] axis,
	output logic load,
	output hte_pkg::hte_cmd_t dc,
	input  hte_pkg::hte_stat_t ds,
	output logic out_valid,
	input  logic out_ready,
	output logic out_status,
	output logic out_point
);
	hte_pkg::state_t st_q, st_d;
	logic [4:0] idx_q, idx_d;
	logic [1:0] k_q, k_d;
	logic pt_q;
	logic stat_q, stat_d;
	logic ov_q, ov_d;
	logic busy_q, busy_d;
	logic ostat_q, opt_q, fire;

	assign in_ready = !busy_q;
	assign load = in_valid && in_ready;
	assign out_valid = ov_q;
	assign out_status = ostat_q;
	assign out_point = opt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= hte_pkg::ST_IDLE;
			idx_q <= '0;
			k_q <= '0;
			pt_q <= 1'b0;
			stat_q <= 1'b0;
			ov_q <= 1'b0;
			busy_q <= 1'b0;
			ostat_q <= 1'b0;
			opt_q <= 1'b0;
		end else begin
			st_q <= st_d;
			idx_q <= idx_d;
			k_q <= k_d;
			stat_q <= stat_d;
			ov_q <= ov_d;
			busy_q <= busy_d;
			if (load) begin
				pt_q <= (cmd == hte_pkg::CMD_POINT);
			end
			// result register, held while the previous transaction waits
			if (fire) begin
				ostat_q <= stat_q;
				opt_q <= pt_q;
			end
		end
	end

	always_comb begin
		st_d = st_q;
		idx_d = idx_q;
		k_d = k_q;
		stat_d = stat_q;
		ov_d = ov_q && !out_ready;
		busy_d = busy_q;
		fire = 1'b0;
		dc = '{op: hte_pkg::OP_NONE, idx: idx_q, k: k_q, pt: pt_q, clr: (k_q == 2'd0)};
		case (st_q)
			hte_pkg::ST_IDLE: begin
				if (load) begin
					busy_d = 1'b1;
					stat_d = 1'b0;
					idx_d = '0;
					k_d = '0;
					case (cmd)
						hte_pkg::CMD_IDENT: begin
							dc.op = hte_pkg::OP_IDENT;
							st_d = hte_pkg::ST_DONE;
						end
						hte_pkg::CMD_TRANS, hte_pkg::CMD_SCALE: st_d = hte_pkg::ST_ELEM;
						hte_pkg::CMD_ROT:
							st_d = (axis == 2'd0) ? hte_pkg::ST_DONE : hte_pkg::ST_ELEM;
						hte_pkg::CMD_PROJ: st_d = hte_pkg::ST_PDOT;
						hte_pkg::CMD_POINT: st_d = hte_pkg::ST_MAC;
						default: st_d = hte_pkg::ST_DONE;
					endcase
				end
			end
			hte_pkg::ST_ELEM: begin
				dc.op = hte_pkg::OP_ELEM;
				st_d = hte_pkg::ST_MAC;
			end
			hte_pkg::ST_PDOT: begin
				// idx[0] picks the dot product, k the term
				dc.op = hte_pkg::OP_PDOT;
				if (idx_q[0]) begin
					idx_d = '0;
					if (k_q == 2'd2) begin
						k_d = '0;
						st_d = hte_pkg::ST_PSAT;
					end else begin
						k_d = k_q + 2'd1;
					end
				end else begin
					idx_d = 5'd1;
				end
			end
			hte_pkg::ST_PSAT: begin
				// wait for last product to land
				if (idx_q == 5'd2) begin
					dc.op = hte_pkg::OP_PSAT;
					idx_d = '0;
					st_d = hte_pkg::ST_DSTART;
				end else begin
					idx_d = idx_q + 5'd1;
				end
			end
			hte_pkg::ST_DSTART: begin
				if (ds.div_zero) begin
					stat_d = 1'b1;
					st_d = hte_pkg::ST_DONE;
				end else begin
					dc.op = hte_pkg::OP_DIVSTART;
					st_d = hte_pkg::ST_DWAIT;
				end
			end
			hte_pkg::ST_DWAIT: begin
				if (!ds.div_busy) st_d = hte_pkg::ST_PFILL;
			end
			hte_pkg::ST_PFILL: begin
				dc.op = hte_pkg::OP_PFILL;
				if (idx_q == 5'd12) begin
					idx_d = 5'd16;
					st_d = hte_pkg::ST_MSTORE;
				end else begin
					idx_d = idx_q + 5'd1;
					st_d = hte_pkg::ST_DSTART;
				end
			end
			hte_pkg::ST_MAC: begin
				dc.op = hte_pkg::OP_MAC;
				k_d = k_q + 2'd1;
				if (k_q == 2'd3) st_d = hte_pkg::ST_MSTORE;
			end
			hte_pkg::ST_MSTORE: begin
				// wait for the last product to reach the accumulator, then store
				if (k_q == 2'd0 && !idx_q[4]) begin
					k_d = 2'd1;
				end else begin
					dc.op = pt_q ? hte_pkg::OP_PSTORE : hte_pkg::OP_MSTORE;
					k_d = '0;
					if (idx_q[4]) begin
						// translation column of projection element
						if (idx_q[1:0] == 2'd2) begin
							idx_d = '0;
							st_d = hte_pkg::ST_MAC;
						end else begin
							idx_d = idx_q + 5'd1;
						end
					end else if (pt_q ? (idx_q[1:0] == 2'd3) : (idx_q[3:0] == 4'd15)) begin
						st_d = pt_q ? hte_pkg::ST_DONE : hte_pkg::ST_COMMIT;
					end else begin
						idx_d = pt_q ? {3'd0, idx_q[1:0] + 2'd1} : idx_q + 5'd1;
						st_d = hte_pkg::ST_MAC;
					end
				end
			end
			hte_pkg::ST_COMMIT: begin
				dc.op = hte_pkg::OP_COMMIT;
				st_d = hte_pkg::ST_DONE;
			end
			hte_pkg::ST_DONE: begin
				if (!ov_q || out_ready) begin
					dc.op = hte_pkg::OP_OUT;
					fire = 1'b1;
					ov_d = 1'b1;
					busy_d = 1'b0;
					st_d = hte_pkg::ST_IDLE;
				end
			end
			default: st_d = hte_pkg::ST_IDLE;
		endcase
	end
endmodule

[hdl/homogeneous_transform_engine.sv]
// Homogeneous 4x4 transform engine: one command a transaction, one result
// per command. Depends on hte_pkg, hte_if, hte_ctrl, hte_datapath, hte_div.
//
// Holds a Q(32-F).F matrix, identity after reset, and premultiplies it by
// translate, scale, rotate or projection matrices, or transforms a point.
// One shared 32x32 multiplier does the matrix and point products, one term
// a cycle; the projection also runs thirteen serial divisions, each one
// started, awaited and written into the elementary matrix in turn, and
// reports a status flag instead when the divisor is zero. One command is
// in flight at a time; a finished result waits in the output register
// while the next command is accepted.
module homogeneous_transform_engine #(
	parameter int FRAC_BITS = hte_pkg::FracBitsDef
) (
	input  logic clk,
	input  logic arst_n,
	hte_if.sink   in_ch,
	hte_if.source out_ch
);
	localparam int W = hte_pkg::DataW;

	logic load, ostat, opt;
	hte_pkg::hte_cmd_t dc;
	hte_pkg::hte_stat_t ds;
	logic signed [W-1:0] ops [9];
	logic signed [W-1:0] pout [4];

	assign ops[0] = in_ch.data.op_a;
	assign ops[1] = in_ch.data.op_b;
	assign ops[2] = in_ch.data.op_c;
	assign ops[3] = in_ch.data.op_d;
	assign ops[4] = in_ch.data.op_e;
	assign ops[5] = in_ch.data.op_f;
	assign ops[6] = in_ch.data.op_g;
	assign ops[7] = in_ch.data.op_h;
	assign ops[8] = in_ch.data.op_i;

	hte_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.cmd(in_ch.data.cmd), .axis(in_ch.data.axis), .load(load), .dc(dc), .ds(ds),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_status(ostat),
		.out_point(opt)
	);

	hte_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .load(load), .cmd(in_ch.data.cmd),
		.axis(in_ch.data.axis), .ops(ops), .dc(dc), .ds(ds), .pout(pout)
	);

	assign out_ch.data.status = ostat;
	assign out_ch.data.out_x = opt ? pout[0] : '0;
	assign out_ch.data.out_y = opt ? pout[1] : '0;
	assign out_ch.data.out_z = opt ? pout[2] : '0;
	assign out_ch.data.out_w = opt ? pout[3] : '0;

`ifndef SYNTHESIS
	ap_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("second transaction accepted while busy");
	ap_status_proj: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.data.status) |-> !opt)
		else $error("zero-divisor status on a point result");
	ap_point_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !opt) |-> (out_ch.data.out_w == '0))
		else $error("matrix command returned a non-zero point");
`endif
endmodule

[tb/tb_homogeneous_transform_engine.sv]
// Self-checking testbench for homogeneous_transform_engine: directed table then
// random command sequences, checked against an in-bench Q16.16 matrix model.
// Depends on hte_pkg, hte_if and the engine RTL.
`timescale 1ns / 1ps

module tb_homogeneous_transform_engine;

	localparam int FB = hte_pkg::FracBitsDef;
	localparam int ONE = 1 << FB;
	localparam int NUM_RAND = 600;

	typedef hte_pkg::hte_in_t xf_cmd_t;
	typedef hte_pkg::hte_out_t xf_res_t;

	typedef struct {
		xf_cmd_t c;
		bit      typed;
		xf_res_t r;
	} row_t;

	logic clk;
	logic arst_n;
	hte_if #(.PT_T(xf_cmd_t)) in_ch ();
	hte_if #(.PT_T(xf_res_t)) out_ch ();

	homogeneous_transform_engine dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch)
	);

	int      mtx [16];
	xf_res_t pending_q [$];
	row_t    rows [$];
	int      errors = 0;
	bit      quiet = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end

	function automatic int sat(longint v);
		if (v > 64'sd2147483647) return 32'h7fffffff;
		if (v < -64'sd2147483648) return 32'h80000000;
		return int'(v);
	endfunction

	// exact product, floor shift
	function automatic longint fmul(longint a, longint b);
		return (a * b) >>> FB;
	endfunction

	function automatic int fdiv(longint a, longint b);
		return sat((a * longint'(ONE)) / b);
	endfunction

	function automatic void set_identity();
		foreach (mtx[i]) mtx[i] = (i % 5 == 0) ? ONE : 0;
	endfunction

	function automatic void premul(int e [16]);
		int     old [16];
		longint acc;
		old = mtx;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++) begin
				acc = 0;
				for (int k = 0; k < 4; k++) acc += fmul(e[r*4+k], old[k*4+c]);
				mtx[r*4+c] = sat(acc);
			end
	endfunction

	function automatic xf_res_t predict_transform(xf_cmd_t c);
		xf_res_t r;
		int      e [16];
		longint  n [3], p [3], q3 [3], pt [4];
		longint  dacc, nacc, acc;
		int      dv, nm, qq;
		r = '0;
		foreach (e[i]) e[i] = (i % 5 == 0) ? ONE : 0;
		case (c.cmd)
			hte_pkg::CMD_IDENT: set_identity();
			hte_pkg::CMD_TRANS: begin
				e[3] = c.op_a; e[7] = c.op_b; e[11] = c.op_c;
				premul(e);
			end
			hte_pkg::CMD_SCALE: begin
				e[0] = c.op_a; e[5] = c.op_b; e[10] = c.op_c;
				premul(e);
			end
			hte_pkg::CMD_ROT: begin
				if (c.axis == hte_pkg::AXIS_X) begin
					e[5] = c.op_a; e[6] = sat(-longint'(c.op_b));
					e[9] = c.op_b; e[10] = c.op_a;
				end else if (c.axis == hte_pkg::AXIS_Y) begin
					e[0] = c.op_a; e[2] = c.op_b;
					e[8] = sat(-longint'(c.op_b)); e[10] = c.op_a;
				end else if (c.axis == hte_pkg::AXIS_Z) begin
					e[0] = c.op_a; e[1] = sat(-longint'(c.op_b));
					e[4] = c.op_b; e[5] = c.op_a;
				end
				if (c.axis != 2'd0) premul(e);
			end
			hte_pkg::CMD_PROJ: begin
				n = '{c.op_a, c.op_b, c.op_c};
				p = '{c.op_d, c.op_e, c.op_f};
				q3 = '{c.op_g, c.op_h, c.op_i};
				dacc = 0; nacc = 0;
				for (int i = 0; i < 3; i++) begin
					dacc += fmul(sat(p[i] - q3[i]), n[i]);
					nacc += fmul(q3[i], n[i]);
				end
				dv = sat(dacc);
				nm = sat(nacc);
				if (dv == 0) begin
					r.status = 1'b1;
				end else begin
					qq = fdiv(nm, dv);
					for (int i = 0; i < 3; i++) begin
						for (int j = 0; j < 3; j++)
							e[i*4+j] = sat((i == j ? ONE : 0) +
								longint'(fdiv(sat(fmul(q3[i], n[j])), dv)));
						e[i*4+3] = sat(-q3[i] - longint'(sat(fmul(qq, q3[i]))));
						e[12+i] = fdiv(n[i], dv);
					end
					e[15] = sat(-longint'(qq));
					premul(e);
				end
			end
			hte_pkg::CMD_POINT: begin
				pt = '{c.op_a, c.op_b, c.op_c, ONE};
				for (int i = 0; i < 4; i++) begin
					acc = 0;
					for (int j = 0; j < 4; j++) acc += fmul(mtx[i*4+j], pt[j]);
					case (i)
						0: r.out_x = sat(acc);
						1: r.out_y = sat(acc);
						2: r.out_z = sat(acc);
						default: r.out_w = sat(acc);
					endcase
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic xf_cmd_t mk(hte_pkg::cmd_t cm, logic [1:0] ax, int a, int b, int cc,
		int d = 0, int e = 0, int f = 0, int g = 0, int h = 0, int i = 0);
		xf_cmd_t c;
		c.cmd = cm; c.axis = ax;
		c.op_a = a; c.op_b = b; c.op_c = cc; c.op_d = d; c.op_e = e;
		c.op_f = f; c.op_g = g; c.op_h = h; c.op_i = i;
		return c;
	endfunction

	function automatic void add_row(xf_cmd_t c, bit typed = 0, xf_res_t r = '0);
		row_t t;
		t.c = c; t.typed = typed; t.r = r;
		rows.push_back(t);
	endfunction

	function automatic xf_res_t pt_res(int x, int y, int z);
		xf_res_t r;
		r = '0;
		r.out_x = x; r.out_y = y; r.out_z = z; r.out_w = ONE;
		return r;
	endfunction

	function automatic int rand_q();
		case ($urandom_range(0, 9))
			0: return int'($urandom);
			1: case ($urandom_range(0, 3))
				0: return 32'h7fffffff;
				1: return 32'h80000000;
				2: return 0;
				default: return -1;
			endcase
			default: return int'($urandom_range(0, 1 << 19)) - (1 << 18);
		endcase
	endfunction

	function automatic xf_cmd_t rand_cmd(hte_pkg::cmd_t cm);
		xf_cmd_t c;
		c = mk(cm, 2'($urandom_range(0, 3)), rand_q(), rand_q(), rand_q(),
			rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
		// occasionally aim for a zero projection divisor: plane point at the centre
		if (cm == hte_pkg::CMD_PROJ && $urandom_range(0, 5) == 0) begin
			c.op_d = c.op_g; c.op_e = c.op_h; c.op_f = c.op_i;
		end
		return c;
	endfunction

	task automatic send(xf_cmd_t c, bit typed, xf_res_t tr);
		xf_res_t pr;
		in_ch.valid <= 1'b1;
		in_ch.data <= c;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		pr = predict_transform(c);
		pending_q.push_back(typed ? tr : pr);
		if (!quiet && $urandom_range(0, 2) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// result side back-pressure
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 4) - 1) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		xf_res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, out_ch.data);
				errors++;
			end else begin
				want = pending_q.pop_front();
				if (out_ch.data.status !== want.status) begin
					$display("%0t: status exp %0d got %0d", $time, want.status,
						out_ch.data.status);
					errors++;
				end
				if (out_ch.data.out_x !== want.out_x) begin
					$display("%0t: out_x exp %h got %h", $time, want.out_x,
						out_ch.data.out_x);
					errors++;
				end
				if (out_ch.data.out_y !== want.out_y) begin
					$display("%0t: out_y exp %h got %h", $time, want.out_y,
						out_ch.data.out_y);
					errors++;
				end
				if (out_ch.data.out_z !== want.out_z) begin
					$display("%0t: out_z exp %h got %h", $time, want.out_z,
						out_ch.data.out_z);
					errors++;
				end
				if (out_ch.data.out_w !== want.out_w) begin
					$display("%0t: out_w exp %h got %h", $time, want.out_w,
						out_ch.data.out_w);
					errors++;
				end
			end
		end
	end

	initial begin
		xf_res_t       zr, st1;
		int            sent, nmat, npts, pick;
		hte_pkg::cmd_t cm;
		zr = '0;
		st1 = '0;
		st1.status = 1'b1;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		set_identity();

		// directed table
		add_row(mk(hte_pkg::CMD_POINT, 0, ONE, 2 * ONE, -3 * ONE), 1,
			pt_res(ONE, 2 * ONE, -3 * ONE));
		add_row(mk(hte_pkg::CMD_POINT, 0, 32'h7fffffff, 32'h80000000, -1), 1,
			pt_res(32'h7fffffff, 32'h80000000, -1));
		add_row(mk(hte_pkg::CMD_TRANS, 0, 5 * ONE, -7 * ONE, ONE / 2), 1, zr);
		add_row(mk(hte_pkg::CMD_POINT, 0, ONE, ONE, ONE));
		add_row(mk(hte_pkg::CMD_IDENT, 0, -1, -1, -1), 1, zr);
		add_row(mk(hte_pkg::CMD_POINT, 0, 0, 0, 0), 1, pt_res(0, 0, 0));
		add_row(mk(hte_pkg::CMD_SCALE, 0, 32'h7fffffff, 32'h80000000, ONE * 3), 1, zr);
		add_row(mk(hte_pkg::CMD_POINT, 0, 32'h7fffffff, 32'h7fffffff, 32'h80000000));
		add_row(mk(hte_pkg::CMD_IDENT, 0, 0, 0, 0), 1, zr);
		add_row(mk(hte_pkg::CMD_ROT, hte_pkg::AXIS_X, 46341, 46341, 0), 1, zr);
		add_row(mk(hte_pkg::CMD_ROT, hte_pkg::AXIS_Y, 0, ONE, 0), 1, zr);
		add_row(mk(hte_pkg::CMD_ROT, hte_pkg::AXIS_Z, -ONE, 32'h80000000, 0), 1, zr);
		add_row(mk(hte_pkg::CMD_ROT, 2'd0, 123, 456, 0), 1, zr);
		add_row(mk(hte_pkg::CMD_POINT, 0, ONE, 2 * ONE, 3 * ONE));
		// zero divisor: plane point equal to centre
		add_row(mk(hte_pkg::CMD_PROJ, 0, ONE, ONE, ONE, ONE, 2 * ONE, 0, ONE, 2 * ONE, 0),
			1, st1);
		add_row(mk(hte_pkg::CMD_PROJ, 0, 0, 0, 0, 9, 9, 9, 1, 1, 1), 1, st1);
		add_row(mk(hte_pkg::CMD_IDENT, 0, 0, 0, 0), 1, zr);
		add_row(mk(hte_pkg::CMD_PROJ, 0, 0, 0, ONE, 0, 0, 4 * ONE, 0, 0, -2 * ONE), 1, zr);
		add_row(mk(hte_pkg::CMD_POINT, 0, ONE, -ONE, 2 * ONE));
		add_row(mk(hte_pkg::CMD_RSV6, 3, -1, -1, -1, -1, -1, -1, -1, -1, -1), 1, zr);
		add_row(mk(hte_pkg::CMD_RSV7, 0, 0, 0, 0), 1, zr);
		add_row(mk(hte_pkg::CMD_POINT, 0, 3 * ONE, ONE, -ONE));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) send(rows[i].c, rows[i].typed, rows[i].r);

		sent = 0;
		while (sent < NUM_RAND) begin
			if (sent > NUM_RAND * 9 / 10) quiet = 1;
			if (sent >= NUM_RAND / 2 && sent < NUM_RAND / 2 + 8) begin
				in_ch.valid <= 1'b0;
				while (pending_q.size() != 0) @(posedge clk);
				@(posedge clk);
			end
			// a well-formed sequence: identity, a few matrix ops, some points
			if ($urandom_range(0, 9) == 0) begin
				send(rand_cmd(hte_pkg::cmd_t'($urandom_range(0, 7))), 0, zr);
				sent++;
			end else begin
				send(rand_cmd(hte_pkg::CMD_IDENT), 0, zr);
				sent++;
				nmat = $urandom_range(1, 3);
				repeat (nmat) begin
					pick = $urandom_range(0, 9);
					cm = pick < 3 ? hte_pkg::CMD_TRANS : pick < 6 ? hte_pkg::CMD_SCALE :
						pick < 9 ? hte_pkg::CMD_ROT : hte_pkg::CMD_PROJ;
					send(rand_cmd(cm), 0, zr);
					sent++;
				end
				npts = $urandom_range(1, 4);
				repeat (npts) begin
					send(rand_cmd(hte_pkg::CMD_POINT), 0, zr);
					sent++;
				end
			end
		end
		in_ch.valid <= 1'b0;

		while (pending_q.size() != 0) @(posedge clk);
		repeat (1000) @(posedge clk);
		if (errors == 0 && pending_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[filelist.f]
hdl/hte_pkg.sv
hdl/hte_if.sv
hdl/hte_div.sv
hdl/hte_datapath.sv
hdl/hte_ctrl.sv
hdl/homogeneous_transform_engine.sv
tb/tb_homogeneous_transform_engine.sv
